>>> src/ptts_pkg.sv
// Shared types for the periodic task tick scheduler.
// Holds the operation codes, the sequencer states and the slot record.
// No dependencies.
package ptts_pkg;

  // Request operation codes
  typedef enum logic [2:0] {
    OP_TICK          = 3'd0,
    OP_DISPATCH      = 3'd1,
    OP_SET_COUNT     = 3'd2,
    OP_SET_SUSPEND   = 3'd3,
    OP_LOAD_INTERVAL = 3'd4
  } op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  localparam int unsigned CNT_W = 8;
  localparam int unsigned IDX_W = 4;

  // One slot as stored in the slot memory
  typedef struct packed {
    logic [CNT_W-1:0] interval;
    logic [CNT_W-1:0] countdown;
    logic             suspended;
    logic             pending;
  } slot_t;

endpackage

>>> src/ptts_slot_mem.sv
// Slot memory of the periodic task tick scheduler: one write port and one
// registered read port; a slot never written since reset reads as zero.
// Depends on ptts_pkg.
module ptts_slot_mem
  import ptts_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output slot_t         rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_t         wr_data
);

  slot_t            mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  slot_t            rd_data_r;
  logic             rd_vld_r;

  // Valid bits stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

>>> src/periodic_task_tick_scheduler_core.sv
// Top level of the periodic task tick scheduler.
// Depends on ptts_pkg and ptts_slot_mem.
//
// The block keeps NUM_TASKS periodic task slots (interval, countdown,
// suspend and pending marks) in one slot memory with a registered read
// port, and serves one request at a time. A tick or a dispatch walks
// the slots in index order with one read-modify-write per cycle, unless
// a dispatch stalls on a busy result register; a dispatch then delivers
// its final result once the result side is free. A set countdown, set
// suspend or load interval request with an index in range is a read,
// then a write back; an out-of-range index or an unused operation code
// is dropped in the cycle it is accepted. The walk length is set by
// the single read port of the slot memory. A dispatch delivers
// each due slot with task_valid high, and marks the final one with last;
// when nothing is due it delivers one result with task_valid low and last
// high. The latest due slot is held one step back in a small buffer so the
// last flag is known when it is sent. All slots read as zero after reset.
module periodic_task_tick_scheduler_core
  import ptts_pkg::*;
#(
  parameter int unsigned NUM_TASKS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_operation,
  input  logic [IDX_W-1:0] in_task_index,
  input  logic [CNT_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_task_index_res,
  output logic             out_task_valid,
  output logic             out_last
);

  localparam int unsigned AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_TASKS - 1);

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [CNT_W-1:0] val_r, val_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic             hold_vld_r, hold_vld_nxt;
  logic [AW-1:0]    hold_idx_r, hold_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic             out_tv_r, out_tv_nxt;
  logic             out_last_r, out_last_nxt;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr;
  slot_t         rd_data, slot_nxt;

  logic       is_walk_op, is_set_op, idx_ok, start;
  logic       due, stall, advance, walk_end, out_free;
  logic [CNT_W-1:0] cd_dec;

  ptts_slot_mem #(
    .DEPTH (NUM_TASKS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (ptr_r),
    .wr_data (slot_nxt)
  );

  // Request decode at the input
  assign is_walk_op = in_operation inside {OP_TICK, OP_DISPATCH};
  assign is_set_op  = in_operation inside {OP_SET_COUNT, OP_SET_SUSPEND, OP_LOAD_INTERVAL};
  assign idx_ok     = {1'b0, in_task_index} < (IDX_W + 1)'(NUM_TASKS);
  assign start      = is_walk_op || (is_set_op && idx_ok);

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Modify the slot read from memory
  always_comb begin
    slot_nxt = rd_data;
    due      = rd_data.pending && !rd_data.suspended;
    cd_dec   = rd_data.countdown - 1'b1;
    case (op_r)
      OP_TICK: begin
        if (rd_data.countdown != '0 && !rd_data.suspended) begin
          if (cd_dec == '0) begin
            slot_nxt.countdown = rd_data.interval;
            slot_nxt.pending   = 1'b1;
          end else begin
            slot_nxt.countdown = cd_dec;
          end
        end
      end
      OP_DISPATCH: begin
        if (due) begin
          slot_nxt.pending = 1'b0;
        end
      end
      OP_SET_COUNT:     slot_nxt.countdown = val_r;
      OP_SET_SUSPEND:   slot_nxt.suspended = |val_r;
      OP_LOAD_INTERVAL: begin
        slot_nxt.interval  = val_r;
        slot_nxt.countdown = val_r;
      end
      default: slot_nxt = rd_data;
    endcase
  end

  // Hold the walk when a second due slot finds the result register busy
  assign stall    = (op_r == OP_DISPATCH) && due && hold_vld_r && !out_free;
  assign walk_end = (op_r != OP_TICK && op_r != OP_DISPATCH) || (ptr_r == LAST_SLOT);
  assign advance  = (state_r == ST_WALK) && !stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && start) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (advance && walk_end) begin
          state_nxt = (op_r == OP_DISPATCH) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory control, pointer, hold buffer and result register
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = ptr_r + 1'b1;
    wr_en         = 1'b0;
    ptr_nxt       = ptr_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    hold_vld_nxt  = hold_vld_r;
    hold_idx_nxt  = hold_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_tv_nxt    = out_tv_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        rd_addr = is_walk_op ? '0 : in_task_index[AW-1:0];
        if (in_valid && start) begin
          rd_en   = 1'b1;
          ptr_nxt = rd_addr;
          op_nxt  = op_t'(in_operation);
          val_nxt = in_value;
        end
      end
      ST_WALK: begin
        if (advance) begin
          wr_en = 1'b1;
          if (!walk_end) begin
            rd_en   = 1'b1;
            ptr_nxt = ptr_r + 1'b1;
          end
          if (op_r == OP_DISPATCH && due) begin
            // Send the earlier due slot; it cannot be the last one
            if (hold_vld_r) begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = IDX_W'(hold_idx_r);
              out_tv_nxt    = 1'b1;
              out_last_nxt  = 1'b0;
            end
            hold_vld_nxt = 1'b1;
            hold_idx_nxt = ptr_r;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = hold_vld_r ? IDX_W'(hold_idx_r) : '0;
          out_tv_nxt    = hold_vld_r;
          out_last_nxt  = 1'b1;
          hold_vld_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    ptr_r      <= ptr_nxt;
    hold_idx_r <= hold_idx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_tv_r   <= out_tv_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_task_index_res = out_idx_r;
  assign out_task_valid     = out_tv_r;
  assign out_last           = out_last_r;

endmodule
